// ===== rtl/mbq_pkg.sv =====
package mbq_pkg;

  // default geometry
  localparam int DEPTH_DEF     = 16;
  localparam int MSG_WIDTH_DEF = 32;

  // capacity register
  localparam int             CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_GET    = 2'd0,
    MODE_POST   = 2'd1,
    MODE_URGENT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // result flags from control to the output packing
  typedef struct packed {
    status_t status;
    logic    handed;
    logic    from_mem;
  } res_flags_t;

endpackage

// ===== rtl/mbq_ram.sv =====
module mbq_ram #(
  parameter int DEPTH     = mbq_pkg::DEPTH_DEF,
  parameter int MSG_WIDTH = mbq_pkg::MSG_WIDTH_DEF,
  localparam int IDX_W    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  logic [MSG_WIDTH-1:0] wdata,
  input  logic                 re,
  input  logic [IDX_W-1:0]     raddr,
  output logic [MSG_WIDTH-1:0] rdata
);

  logic [MSG_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mbq_ctrl.sv =====
module mbq_ctrl #(
  parameter int DEPTH     = mbq_pkg::DEPTH_DEF,
  parameter int MSG_WIDTH = mbq_pkg::MSG_WIDTH_DEF,
  localparam int IDX_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  input  logic [mbq_pkg::CAP_W-1:0]    cfg_data,
  // request side
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   req_mode,
  input  logic [MSG_WIDTH-1:0]         req_msg,
  input  logic                         req_waiter,
  // result side
  output logic                         res_valid,
  input  logic                         res_ready,
  output mbq_pkg::res_flags_t          res_flags,
  output logic [MSG_WIDTH-1:0]         res_msg,
  output logic [CNT_W-1:0]             res_fill,
  // memory port
  output logic                         mem_we,
  output logic [IDX_W-1:0]             mem_waddr,
  output logic                         mem_re,
  output logic [IDX_W-1:0]             mem_raddr
);

  localparam int W = (CNT_W > mbq_pkg::CAP_W) ? CNT_W : mbq_pkg::CAP_W;

  logic [mbq_pkg::CAP_W-1:0] capacity;
  logic [IDX_W-1:0]          read_index, read_index_next;
  logic [IDX_W-1:0]          write_index, write_index_next;
  logic [CNT_W-1:0]          stored_count, stored_count_next;

  logic [W-1:0]     cap_wide;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] rd_inc, wr_inc;
  logic [IDX_W-1:0] rd_fwd, wr_fwd, rd_back;
  logic             accept;
  logic             post_full;
  mbq_pkg::res_flags_t flags_next;
  logic             store_post;

  // clamp capacity to 1..DEPTH
  always_comb begin
    cap_wide = W'(capacity);
    if (capacity == '0) begin
      cap_wide = W'(1);
    end else if (cap_wide > W'(DEPTH)) begin
      cap_wide = W'(DEPTH);
    end
    cap = cap_wide[CNT_W-1:0];
  end

  // ring index steps, wrapping inside the active capacity
  assign rd_inc  = CNT_W'(read_index) + CNT_W'(1);
  assign wr_inc  = CNT_W'(write_index) + CNT_W'(1);
  assign rd_fwd  = (rd_inc >= cap) ? '0 : rd_inc[IDX_W-1:0];
  assign wr_fwd  = (wr_inc >= cap) ? '0 : wr_inc[IDX_W-1:0];
  assign rd_back = (read_index == '0) ? IDX_W'(cap - CNT_W'(1))
                                      : read_index - IDX_W'(1);

  assign req_ready = !res_valid || res_ready;
  assign accept    = req_valid && req_ready;
  assign post_full = stored_count >= cap;

  always_comb begin
    read_index_next   = read_index;
    write_index_next  = write_index;
    stored_count_next = stored_count;
    flags_next        = '{status: mbq_pkg::ST_OK, handed: 1'b0, from_mem: 1'b0};
    store_post        = 1'b0;
    mem_re            = 1'b0;
    mem_waddr         = write_index;
    case (mbq_pkg::mode_t'(req_mode))
      mbq_pkg::MODE_GET: begin
        if (stored_count != '0) begin
          stored_count_next   = stored_count - CNT_W'(1);
          read_index_next     = rd_fwd;
          mem_re              = accept;
          flags_next.from_mem = 1'b1;
        end else begin
          flags_next.status = mbq_pkg::ST_EMPTY;
        end
      end
      mbq_pkg::MODE_POST, mbq_pkg::MODE_URGENT: begin
        if (req_waiter) begin
          flags_next.handed = 1'b1;
        end else if (post_full) begin
          flags_next.status = mbq_pkg::ST_FULL;
        end else begin
          store_post        = 1'b1;
          stored_count_next = stored_count + CNT_W'(1);
          if (req_mode == mbq_pkg::MODE_URGENT) begin
            read_index_next = rd_back;
            mem_waddr       = rd_back;
          end else begin
            write_index_next = wr_fwd;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we    = accept && store_post;
  assign mem_raddr = read_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= mbq_pkg::CAP_RESET;
      read_index   <= '0;
      write_index  <= '0;
      stored_count <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        read_index   <= read_index_next;
        write_index  <= write_index_next;
        stored_count <= stored_count_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_flags <= flags_next;
      res_msg   <= flags_next.handed ? req_msg : '0;
      res_fill  <= stored_count_next;
    end
  end

endmodule

// ===== rtl/mailbox_ring_queue.sv =====
// mailbox_ring_queue: bounded message mailbox kept in a ring memory
//
// requests enter on s_axis: tuser carries the mode (get, post at tail,
// urgent post at head) and the waiter flag, tdata the message word.
// every request gives exactly one response on m_axis: status, the message
// popped or handed to a waiter, and the fill count after the request;
// tuser marks a hand-over to a waiter.
// capacity is written on the cfg channel (always ready); the user must write
// it only while idle, the block does not enforce this; 0 acts as 1 and values
// above DEPTH act as DEPTH. the response is registered, valid in the cycle
// after the request is taken. throughput: one request per cycle while m_axis
// takes each response; the single memory is written at the request edge and
// a get reads it at that same edge, so the next request always sees the update.
// a stalled m_axis holds its response and s_axis_tready drops until it
// is taken, so the memory read register is never overwritten.
// reset clears indices and count and sets capacity to 16; stored words
// are not cleared and are only read after being written.
module mailbox_ring_queue #(
  parameter int DEPTH     = mbq_pkg::DEPTH_DEF,
  parameter int MSG_WIDTH = mbq_pkg::MSG_WIDTH_DEF,
  localparam int IDX_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int IN_W     = ((MSG_WIDTH + 7) / 8) * 8,
  localparam int OUT_W    = ((2 + MSG_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write: capacity
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mbq_pkg::CAP_W-1:0] cfg_data,
  // request stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_W-1:0]           s_axis_tdata,  // message_in
  input  logic [2:0]                s_axis_tuser,  // mode[1:0], waiter_present
  // response stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,  // status[1:0], message_out, fill_count
  output logic                      m_axis_tuser   // handed_to_waiter
);

  mbq_pkg::res_flags_t  res_flags;
  logic [MSG_WIDTH-1:0] res_msg;
  logic [MSG_WIDTH-1:0] mem_rdata;
  logic [MSG_WIDTH-1:0] msg_out;
  logic [CNT_W-1:0]     res_fill;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;

  assign cfg_ready = 1'b1;

  mbq_ctrl #(
    .DEPTH     (DEPTH),
    .MSG_WIDTH (MSG_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .req_valid  (s_axis_tvalid),
    .req_ready  (s_axis_tready),
    .req_mode   (s_axis_tuser[1:0]),
    .req_msg    (s_axis_tdata[MSG_WIDTH-1:0]),
    .req_waiter (s_axis_tuser[2]),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_flags  (res_flags),
    .res_msg    (res_msg),
    .res_fill   (res_fill),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  // message store, at most one write or one read per request
  mbq_ram #(
    .DEPTH     (DEPTH),
    .MSG_WIDTH (MSG_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (s_axis_tdata[MSG_WIDTH-1:0]),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // a successful get answers with the registered memory word
  assign msg_out = res_flags.from_mem ? mem_rdata : res_msg;

  assign m_axis_tdata = OUT_W'({res_fill, msg_out, res_flags.status});
  assign m_axis_tuser = res_flags.handed;

endmodule
